[hdl/tsc_pkg.sv]
package tsc_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int ENTRY_BYTES  = 8;
  localparam int MAX_ENTRIES  = 128;

  localparam int CMD_W   = 3;
  localparam int STAT_W  = 3;
  localparam int KEY_W   = 16;
  localparam int LEN_W   = 11;
  localparam int OFF_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int BOFF_W  = 10;
  localparam int SLOT_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int VADDR_W = $clog2(BUFFER_BYTES);

  localparam logic [CMD_W-1:0] CMD_ADD_HEADER = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_DATA   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_BYTE  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_PENDING = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] off;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/tsc_ram.sv]
module tsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tlv_store_with_compaction.sv]
// Keyed type-length-value store over one byte region.
// Input channel (in_valid/in_stall) takes one command beat: add header, add
// data byte, lookup, remove or read byte. Output channel (out_valid/out_stall)
// returns one result beat per command, held in an output register, so the
// next command is taken while a result still waits to be drained.
// Add data byte and unknown codes go from idle through the done state to the
// output register. Lookup/remove/read/add walk the entry table, reading and
// then checking each entry (one read port of the entry RAM).
// An add that runs short of space compacts: one pass over the entries closes up
// the table, a second re-places values, each value byte moved is read and then
// written (one port of the value RAM), then the space check is repeated.
// Reset, and any cfg_write, empties the store and runs a clearing pass
// over all BUFFER_BYTES bytes of the value RAM; no command is taken then.
// A stalled receiver only holds the output register; a finished command
// waits for it before the block goes idle again.
module tlv_store_with_compaction (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tsc_pkg::LEN_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tsc_pkg::CMD_W-1:0]     command,
  input  logic [tsc_pkg::KEY_W-1:0]     key,
  input  logic [tsc_pkg::LEN_W-1:0]     value_length,
  input  logic [tsc_pkg::BYTE_W-1:0]    data_byte,
  input  logic [tsc_pkg::BOFF_W-1:0]    byte_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tsc_pkg::STAT_W-1:0]    status,
  output logic [tsc_pkg::SLOT_W-1:0]    slot,
  output logic [tsc_pkg::OFF_W-1:0]     data_offset,
  output logic [tsc_pkg::LEN_W-1:0]     stored_length,
  output logic [tsc_pkg::BYTE_W-1:0]    read_data,
  output logic [tsc_pkg::OFF_W-1:0]     free_bytes
);
  import tsc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_FOUND, S_RD_DATA,
    S_TRIM_RD, S_TRIM_CHK, S_CHECK, S_CMP1_RD, S_CMP1_CHK,
    S_CMP2_RD, S_CMP2_CHK, S_MV_RD, S_MV_WR, S_DONE
  } state_t;

  state_t state;

  // configuration and table bookkeeping
  logic [LEN_W-1:0]   cfg_bytes;
  logic [CNT_W-1:0]   count;
  logic [OFF_W-1:0]   last_off;      // offset of entry count-1 when count != 0
  logic [OFF_W-1:0]   pend_addr;
  logic [LEN_W-1:0]   pend_cnt;
  logic [VADDR_W-1:0] clr_addr;

  // command being worked on
  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [LEN_W-1:0]   vlen_r;
  logic [BOFF_W-1:0]  boff_r;

  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   wr;
  logic [SLOT_W-1:0]  f_idx;
  logic               found;
  entry_t             ent;
  logic               compacted;
  logic               trim_chk;      // after trim, go to space check

  // compaction value move
  logic [OFF_W-1:0]   wp;
  logic [OFF_W-1:0]   mv_src;
  logic [OFF_W-1:0]   mv_dst;
  logic [LEN_W-1:0]   mv_cnt;
  logic               mv_up;

  // pending result
  logic [STAT_W-1:0]  r_status;
  logic [SLOT_W-1:0]  r_slot;
  logic [OFF_W-1:0]   r_doff;
  logic [LEN_W-1:0]   r_slen;
  logic [BYTE_W-1:0]  r_rdata;

  // RAM ports
  logic               e_we;
  logic [SLOT_W-1:0]  e_waddr;
  logic [SLOT_W-1:0]  e_raddr;
  entry_t             e_wdata;
  logic [ENTRY_W-1:0] e_rvec;
  entry_t             e_rdata;
  logic               v_we;
  logic [VADDR_W-1:0] v_waddr;
  logic [VADDR_W-1:0] v_raddr;
  logic [BYTE_W-1:0]  v_wdata;
  logic [BYTE_W-1:0]  v_rdata;

  tsc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rvec)
  );

  tsc_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_BYTES)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  assign e_rdata = entry_t'(e_rvec);

  // derived values
  logic               acc;
  logic [OFF_W-1:0]   limit;
  logic [OFF_W:0]     tbl_end;
  logic [OFF_W-1:0]   free_now;
  logic [OFF_W:0]     need;
  logic               no_room;
  logic [OFF_W-1:0]   alloc_off;
  logic [SLOT_W-1:0]  last_slot;
  logic               fits;
  logic [OFF_W:0]     rd_addr;
  logic               c_skip;
  logic [OFF_W-1:0]   c_wp;

  assign in_stall  = (state != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign limit     = (cfg_bytes > OFF_W'(BUFFER_BYTES)) ? OFF_W'(BUFFER_BYTES) : cfg_bytes;
  assign tbl_end   = (OFF_W+1)'(count) * (OFF_W+1)'(ENTRY_BYTES);
  assign free_now  = (count == '0) ? limit :
                     ({1'b0, last_off} > tbl_end) ? OFF_W'({1'b0, last_off} - tbl_end) : '0;
  assign need      = {1'b0, vlen_r} + (OFF_W+1)'(ENTRY_BYTES);
  assign no_room   = ({1'b0, free_now} < need) || (count >= CNT_W'(MAX_ENTRIES));
  assign alloc_off = ((count != '0) ? last_off : limit) - vlen_r;
  assign last_slot = SLOT_W'(count - 1'b1);
  assign fits      = found && (ent.len >= vlen_r);
  assign rd_addr   = {1'b0, ent.off} + (OFF_W+1)'(boff_r);

  // a value that is empty, does not fit below wp or does not lie inside the buffer is left where it is
  assign c_skip = (e_rdata.len == '0) || (e_rdata.len > wp) ||
                  (e_rdata.off > OFF_W'(BUFFER_BYTES)) ||
                  ({1'b0, e_rdata.len} > ((OFF_W+1)'(BUFFER_BYTES) - {1'b0, e_rdata.off}));
  assign c_wp   = wp - e_rdata.len;

  always_comb begin
    e_we    = 1'b0;
    e_waddr = f_idx;
    e_wdata = '0;
    e_raddr = idx[SLOT_W-1:0];
    v_we    = 1'b0;
    v_waddr = pend_addr[VADDR_W-1:0];
    v_wdata = data_byte;
    v_raddr = mv_src[VADDR_W-1:0];
    unique case (state)
      S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_addr;
        v_wdata = '0;
      end
      S_IDLE: begin
        if (acc && command == CMD_ADD_DATA && pend_cnt != '0 &&
            pend_addr < OFF_W'(BUFFER_BYTES)) begin
          v_we = 1'b1;
        end
      end
      S_TRIM_RD: begin
        e_raddr = last_slot;
      end
      S_FOUND: begin
        if (found) begin
          if (cmd_r == CMD_REMOVE) begin
            e_we = 1'b1;
          end else if (cmd_r == CMD_ADD_HEADER) begin
            e_we = 1'b1;
            if (fits) begin
              e_wdata = '{key: ent.key, len: vlen_r, off: ent.off};
            end
          end else if (cmd_r == CMD_READ_BYTE) begin
            v_raddr = rd_addr[VADDR_W-1:0];
          end
        end
      end
      S_CHECK: begin
        if (!no_room) begin
          e_we    = 1'b1;
          e_waddr = count[SLOT_W-1:0];
          e_wdata = '{key: key_r, len: vlen_r, off: alloc_off};
        end
      end
      S_CMP1_CHK: begin
        if (e_rdata.len != '0) begin
          e_we    = 1'b1;
          e_waddr = wr[SLOT_W-1:0];
          e_wdata = e_rdata;
        end
      end
      S_CMP2_CHK: begin
        if (!c_skip && c_wp != e_rdata.off) begin
          e_we    = 1'b1;
          e_waddr = idx[SLOT_W-1:0];
          e_wdata = '{key: e_rdata.key, len: e_rdata.len, off: c_wp};
        end
      end
      S_MV_WR: begin
        v_we    = 1'b1;
        v_waddr = mv_dst[VADDR_W-1:0];
        v_wdata = v_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cfg_bytes <= LEN_W'(BUFFER_BYTES);
      count     <= '0;
      last_off  <= '0;
      pend_addr <= '0;
      pend_cnt  <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      compacted <= 1'b0;
      trim_chk  <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself when it drains
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        // region rewrite: store emptied, value RAM swept again
        cfg_bytes <= cfg_data;
        count     <= '0;
        last_off  <= '0;
        pend_addr <= '0;
        pend_cnt  <= '0;
        clr_addr  <= '0;
        state     <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == VADDR_W'(BUFFER_BYTES - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (acc) begin
              cmd_r     <= command;
              key_r     <= key;
              vlen_r    <= value_length;
              boff_r    <= byte_offset;
              idx       <= '0;
              found     <= 1'b0;
              compacted <= 1'b0;
              trim_chk  <= 1'b0;
              r_slot    <= '0;
              r_rdata   <= '0;
              if (command == CMD_ADD_DATA) begin
                if (pend_cnt == '0) begin
                  r_status <= ST_NO_PENDING;
                  r_doff   <= '0;
                  r_slen   <= '0;
                end else begin
                  r_status  <= ST_OK;
                  r_doff    <= pend_addr;
                  r_slen    <= pend_cnt - 1'b1;
                  pend_addr <= pend_addr + 1'b1;
                  pend_cnt  <= pend_cnt - 1'b1;
                end
                state <= S_DONE;
              end else begin
                r_status <= ST_OK;
                r_doff   <= '0;
                r_slen   <= '0;
                pend_cnt <= '0;
                if (command == CMD_ADD_HEADER || command == CMD_LOOKUP ||
                    command == CMD_REMOVE || command == CMD_READ_BYTE) begin
                  state <= S_SCAN_RD;
                end else begin
                  state <= S_DONE;
                end
              end
            end
          end
          S_SCAN_RD: begin
            if (idx >= count) begin
              state <= S_FOUND;
            end else begin
              state <= S_SCAN_CHK;
            end
          end
          S_SCAN_CHK: begin
            if (e_rdata.len != '0 && e_rdata.key == key_r) begin
              found <= 1'b1;
              f_idx <= idx[SLOT_W-1:0];
              ent   <= e_rdata;
              state <= S_FOUND;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_SCAN_RD;
            end
          end
          S_FOUND: begin
            if (cmd_r == CMD_ADD_HEADER) begin
              if (fits) begin
                r_slot    <= f_idx;
                r_doff    <= ent.off;
                r_slen    <= vlen_r;
                pend_addr <= ent.off;
                pend_cnt  <= vlen_r;
              end else begin
                trim_chk <= 1'b1;
              end
              state <= S_TRIM_RD;
            end else if (!found) begin
              r_status <= ST_NOT_FOUND;
              state    <= S_DONE;
            end else if (cmd_r == CMD_READ_BYTE) begin
              if ((LEN_W+1)'(boff_r) >= (LEN_W+1)'(ent.len)) begin
                r_status <= ST_RANGE;
                state    <= S_DONE;
              end else begin
                r_slot <= f_idx;
                r_doff <= ent.off;
                r_slen <= ent.len;
                state  <= (rd_addr < (OFF_W+1)'(BUFFER_BYTES)) ? S_RD_DATA : S_DONE;
              end
            end else begin
              // lookup, or remove reporting the entry before it is cleared
              r_slot <= f_idx;
              r_doff <= ent.off;
              r_slen <= ent.len;
              state  <= (cmd_r == CMD_REMOVE) ? S_TRIM_RD : S_DONE;
            end
          end
          S_RD_DATA: begin
            r_rdata <= v_rdata;
            state   <= S_DONE;
          end
          S_TRIM_RD: begin
            if (count == '0) begin
              state <= trim_chk ? S_CHECK : S_DONE;
            end else begin
              state <= S_TRIM_CHK;
            end
          end
          S_TRIM_CHK: begin
            if (e_rdata.len == '0) begin
              count <= count - 1'b1;
              state <= S_TRIM_RD;
            end else begin
              last_off <= e_rdata.off;
              state    <= trim_chk ? S_CHECK : S_DONE;
            end
          end
          S_CHECK: begin
            if (no_room) begin
              if (compacted) begin
                r_status <= ST_NO_SPACE;
                state    <= S_DONE;
              end else begin
                idx   <= '0;
                wr    <= '0;
                state <= S_CMP1_RD;
              end
            end else begin
              count     <= count + 1'b1;
              last_off  <= alloc_off;
              r_slot    <= count[SLOT_W-1:0];
              r_doff    <= alloc_off;
              r_slen    <= vlen_r;
              pend_addr <= alloc_off;
              pend_cnt  <= vlen_r;
              trim_chk  <= 1'b0;
              state     <= S_TRIM_RD;   // a zero length entry drops off at once
            end
          end
          // close up live entries at the table start, order kept
          S_CMP1_RD: begin
            if (idx >= count) begin
              count <= wr;
              idx   <= '0;
              wp    <= limit;
              state <= S_CMP2_RD;
            end else begin
              state <= S_CMP1_CHK;
            end
          end
          S_CMP1_CHK: begin
            if (e_rdata.len != '0) begin
              wr <= wr + 1'b1;
            end
            idx   <= idx + 1'b1;
            state <= S_CMP1_RD;
          end
          // pack values down from the region top
          S_CMP2_RD: begin
            if (idx >= count) begin
              compacted <= 1'b1;
              trim_chk  <= 1'b1;
              state     <= S_TRIM_RD;
            end else begin
              state <= S_CMP2_CHK;
            end
          end
          S_CMP2_CHK: begin
            if (!c_skip) begin
              wp <= c_wp;
            end
            if (!c_skip && c_wp != e_rdata.off) begin
              mv_cnt <= e_rdata.len;
              mv_up  <= (c_wp < e_rdata.off);
              if (c_wp < e_rdata.off) begin
                mv_src <= e_rdata.off;
                mv_dst <= c_wp;
              end else begin
                // overlapping move upward: copy from the top byte down
                mv_src <= e_rdata.off + e_rdata.len - 1'b1;
                mv_dst <= c_wp + e_rdata.len - 1'b1;
              end
              state <= S_MV_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_CMP2_RD;
            end
          end
          S_MV_RD: begin
            if (mv_cnt == '0) begin
              idx   <= idx + 1'b1;
              state <= S_CMP2_RD;
            end else begin
              state <= S_MV_WR;
            end
          end
          S_MV_WR: begin
            if (mv_up) begin
              mv_src <= mv_src + 1'b1;
              mv_dst <= mv_dst + 1'b1;
            end else begin
              mv_src <= mv_src - 1'b1;
              mv_dst <= mv_dst - 1'b1;
            end
            mv_cnt <= mv_cnt - 1'b1;
            state  <= S_MV_RD;
          end
          S_DONE: begin
            if (!out_valid || !out_stall) begin
              out_valid     <= 1'b1;
              status        <= r_status;
              slot          <= r_slot;
              data_offset   <= r_doff;
              stored_length <= r_slen;
              read_data     <= r_rdata;
              free_bytes    <= free_now;
              state         <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule
